// ===== design/fpc_pkg.sv =====
package fpc_pkg;

  // Largest payload the parser buffers; the payload memory has this many entries.
  localparam int MAX_PAYLOAD = 32;
  localparam int PAY_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int FILL_W      = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  // Field widths fixed by the frame format.
  localparam int ST_W       = 3;
  localparam int IDX_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_GOOD  = 3'd0;
  localparam logic [ST_W-1:0] ST_LEN   = 3'd1;
  localparam logic [ST_W-1:0] ST_CRC   = 3'd2;
  localparam logic [ST_W-1:0] ST_KIND  = 3'd3;
  localparam logic [ST_W-1:0] ST_BCAST = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT = 2'd2;

  localparam logic [7:0]  BCAST_ADDR = 8'hFF;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // Request from the parser to the result stage, with the header it reports.
  typedef struct packed {
    logic            single;
    logic            run;
    logic [ST_W-1:0] status;
    logic [7:0]      dest;
    logic [7:0]      source;
    logic [7:0]      kind;
    logic [7:0]      seq;
    logic [7:0]      len;
  } fpc_req_t;

  // One byte of the reflected CRC-16/MODBUS update.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/fpc_emitter.sv =====
module fpc_emitter (
  input  logic                       clk,
  input  logic                       rst,
  input  fpc_pkg::fpc_req_t          req,
  input  logic                       wr_en,
  input  logic [fpc_pkg::PAY_AW-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       run_busy,
  output logic [fpc_pkg::ST_W-1:0]   status,
  output logic [7:0]                 dest_addr,
  output logic [7:0]                 source_addr,
  output logic [7:0]                 msg_kind,
  output logic [7:0]                 seq_num,
  output logic [7:0]                 payload_len,
  output logic                       has_data,
  output logic [7:0]                 data_byte,
  output logic [fpc_pkg::IDX_W-1:0]  data_index,
  output logic                       last
);
  import fpc_pkg::*;

  logic [7:0]        mem [MAX_PAYLOAD];
  logic [7:0]        rd_data;
  logic [PAY_AW-1:0] rd_idx;
  logic [PAY_AW-1:0] rd_pos;
  logic              rd_pending;
  logic              out_free;
  logic              rd_issue;
  logic              rd_last;

  // The output register can take a word when it is empty or being taken now.
  assign out_free = !out_valid || !out_stall;
  // One read in flight at a time, and only when its word has a place to land.
  assign rd_issue = run_busy && !rd_pending && out_free;
  assign rd_last  = ((8'(rd_pos) + 8'd1) == req.len);

  // Payload memory. Writes come only while a frame is parsed and reads only
  // during a run, when the input side is stalled, so the two never overlap.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

  // Run sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_busy   <= 1'b0;
      rd_pending <= 1'b0;
      rd_idx     <= '0;
      rd_pos     <= '0;
    end else begin
      if (req.run) begin
        run_busy <= 1'b1;
        rd_idx   <= '0;
      end
      if (rd_issue) begin
        rd_pending <= 1'b1;
        rd_pos     <= rd_idx;
        rd_idx     <= rd_idx + 1'b1;
      end
      if (rd_pending) begin
        rd_pending <= 1'b0;
        if (rd_last) begin
          run_busy <= 1'b0;
        end
      end
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.single || rd_pending) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register word.
  always_ff @(posedge clk) begin
    if (req.single || rd_pending) begin
      dest_addr   <= req.dest;
      source_addr <= req.source;
      msg_kind    <= req.kind;
      seq_num     <= req.seq;
      payload_len <= req.len;
    end
    if (req.single) begin
      status     <= req.status;
      has_data   <= 1'b0;
      data_byte  <= 8'h00;
      data_index <= '0;
      last       <= 1'b1;
    end else if (rd_pending) begin
      status     <= ST_GOOD;
      has_data   <= 1'b1;
      data_byte  <= rd_data;
      data_index <= IDX_W'(rd_pos);
      last       <= rd_last;
    end
  end

`ifndef SYNTHESIS
  // A read result always finds the output register empty.
  a_pending_lands: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> !out_valid)
    else $error("payload read returned while the output register was full");

  // Reads are only in flight during a run.
  a_pending_in_run: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> run_busy)
    else $error("payload read outside a run");

  // A run starts with the output register drained.
  a_run_start_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(run_busy) |-> !out_valid)
    else $error("run started over a waiting word");
`endif

endmodule

// ===== design/frame_parser_crc16_core.sv =====
// Channel   Direction  Handshake            Word
// input     in         in_valid/in_stall    rx_byte, now_ms
// output    out        out_valid/out_stall  status, header bytes, payload byte, index, last
// config    in         cfg_write            cfg_index, cfg_data
//
// A received byte is accepted at a clock edge; the parser state updates at that edge.
// A good frame's payload leaves one word at a time, with the next payload read issued only once
// the last word has landed, as set by the registered read of the payload memory feeding the single output register.
// The input stalls during a payload run, and in the length and CRC-high phases
// while the output register holds a word that is stalled.
// Reset is synchronous; the payload memory needs no clearing pass.
module frame_parser_crc16_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [fpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  input  logic [31:0]                    now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fpc_pkg::ST_W-1:0]       status,
  output logic [7:0]                     dest_addr,
  output logic [7:0]                     source_addr,
  output logic [7:0]                     msg_kind,
  output logic [7:0]                     seq_num,
  output logic [7:0]                     payload_len,
  output logic                           has_data,
  output logic [7:0]                     data_byte,
  output logic [fpc_pkg::IDX_W-1:0]      data_index,
  output logic                           last
);
  import fpc_pkg::*;

  localparam logic [3:0] PH_SYNC1 = 4'd0;
  localparam logic [3:0] PH_SYNC2 = 4'd1;
  localparam logic [3:0] PH_DST   = 4'd2;
  localparam logic [3:0] PH_SRC   = 4'd3;
  localparam logic [3:0] PH_KIND  = 4'd4;
  localparam logic [3:0] PH_SEQ   = 4'd5;
  localparam logic [3:0] PH_LEN   = 4'd6;
  localparam logic [3:0] PH_DATA  = 4'd7;
  localparam logic [3:0] PH_CRCLO = 4'd8;
  localparam logic [3:0] PH_CRCHI = 4'd9;

  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [15:0] gap_timeout_ms;

  logic [3:0]        phase, phase_next;
  logic [7:0]        hdr_dest, hdr_dest_next;
  logic [7:0]        hdr_source, hdr_source_next;
  logic [7:0]        hdr_kind, hdr_kind_next;
  logic [7:0]        hdr_seq, hdr_seq_next;
  logic [7:0]        hdr_len, hdr_len_next;
  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic [15:0]       running_crc, running_crc_next;
  logic [7:0]        crc_low_byte, crc_low_byte_next;
  logic [31:0]       prev_time, prev_time_next;

  logic              accept;
  logic              timed_out;
  logic              clear_now;
  logic [3:0]        work_phase;
  logic [15:0]       crc_step;
  logic [FILL_W-1:0] fill_inc;
  logic [ST_W-1:0]   check_status;
  logic              run_busy;
  logic              wr_en;
  fpc_req_t          req;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first     <= 8'hAA;
      sync_second    <= 8'h55;
      gap_timeout_ms <= 16'd50;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first     <= cfg_data[7:0];
        CFG_SYNC_SECOND: sync_second    <= cfg_data[7:0];
        CFG_GAP_TIMEOUT: gap_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold bytes off during a run, and in the phases that may produce a
  // result while the output register is stalled.
  assign in_stall = run_busy ||
                    (out_valid && out_stall && (phase == PH_LEN || phase == PH_CRCHI));
  assign accept   = in_valid && !in_stall;

  // Inter-byte gap with wrapping subtraction.
  assign timed_out  = (phase != PH_SYNC1) && ((now_ms - prev_time) > {16'h0000, gap_timeout_ms});
  assign work_phase = timed_out ? PH_SYNC1 : phase;
  assign crc_step   = crc16_byte(running_crc, rx_byte);
  assign fill_inc   = fill_count + 1'b1;

  // Frame checks, in priority order.
  always_comb begin
    if ({rx_byte, crc_low_byte} != running_crc) begin
      check_status = ST_CRC;
    end else if (hdr_kind == 8'h00) begin
      check_status = ST_KIND;
    end else if (hdr_source == BCAST_ADDR) begin
      check_status = ST_BCAST;
    end else begin
      check_status = ST_GOOD;
    end
  end

  // Parser next state.
  always_comb begin
    phase_next        = phase;
    hdr_dest_next     = hdr_dest;
    hdr_source_next   = hdr_source;
    hdr_kind_next     = hdr_kind;
    hdr_seq_next      = hdr_seq;
    hdr_len_next      = hdr_len;
    fill_count_next   = fill_count;
    running_crc_next  = running_crc;
    crc_low_byte_next = crc_low_byte;
    prev_time_next    = prev_time;
    clear_now         = 1'b0;
    wr_en             = 1'b0;
    req.single        = 1'b0;
    req.run           = 1'b0;
    req.status        = ST_GOOD;
    req.dest          = hdr_dest;
    req.source        = hdr_source;
    req.kind          = hdr_kind;
    req.seq           = hdr_seq;
    req.len           = hdr_len;
    if (accept) begin
      prev_time_next = now_ms;
      // A late byte drops the partial frame and is handled as idle.
      if (timed_out) begin
        phase_next        = PH_SYNC1;
        hdr_dest_next     = 8'h00;
        hdr_source_next   = 8'h00;
        hdr_kind_next     = 8'h00;
        hdr_seq_next      = 8'h00;
        hdr_len_next      = 8'h00;
        fill_count_next   = '0;
        running_crc_next  = CRC_INIT;
        crc_low_byte_next = 8'h00;
      end
      unique case (work_phase)
        PH_SYNC1: begin
          if (rx_byte == sync_first) begin
            phase_next = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          // The second sync wins when both sync values are equal.
          if (rx_byte == sync_second) begin
            phase_next       = PH_DST;
            running_crc_next = CRC_INIT;
          end else if (rx_byte != sync_first) begin
            phase_next = PH_SYNC1;
          end
        end
        PH_DST: begin
          hdr_dest_next    = rx_byte;
          running_crc_next = crc_step;
          phase_next       = PH_SRC;
        end
        PH_SRC: begin
          hdr_source_next  = rx_byte;
          running_crc_next = crc_step;
          phase_next       = PH_KIND;
        end
        PH_KIND: begin
          hdr_kind_next    = rx_byte;
          running_crc_next = crc_step;
          phase_next       = PH_SEQ;
        end
        PH_SEQ: begin
          hdr_seq_next     = rx_byte;
          running_crc_next = crc_step;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          hdr_len_next     = rx_byte;
          running_crc_next = crc_step;
          fill_count_next  = '0;
          if (rx_byte > MAX_LEN) begin
            req.single = 1'b1;
            req.status = ST_LEN;
            req.len    = rx_byte;
            clear_now  = 1'b1;
          end else if (rx_byte == 8'h00) begin
            phase_next = PH_CRCLO;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          wr_en            = (fill_count < FILL_W'(MAX_PAYLOAD));
          running_crc_next = crc_step;
          fill_count_next  = fill_inc;
          if (8'(fill_inc) >= hdr_len) begin
            phase_next = PH_CRCLO;
          end
        end
        PH_CRCLO: begin
          crc_low_byte_next = rx_byte;
          phase_next        = PH_CRCHI;
        end
        PH_CRCHI: begin
          phase_next = PH_SYNC1;
          if (check_status != ST_GOOD) begin
            req.single = 1'b1;
            req.status = check_status;
            clear_now  = 1'b1;
          end else if (hdr_len == 8'h00) begin
            req.single = 1'b1;
          end else begin
            req.run = 1'b1;
          end
        end
        default: begin
          clear_now = 1'b1;
        end
      endcase
      // Rejected frames and stray phase codes resynchronize.
      if (clear_now) begin
        phase_next        = PH_SYNC1;
        hdr_dest_next     = 8'h00;
        hdr_source_next   = 8'h00;
        hdr_kind_next     = 8'h00;
        hdr_seq_next      = 8'h00;
        hdr_len_next      = 8'h00;
        fill_count_next   = '0;
        running_crc_next  = CRC_INIT;
        crc_low_byte_next = 8'h00;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      hdr_dest     <= 8'h00;
      hdr_source   <= 8'h00;
      hdr_kind     <= 8'h00;
      hdr_seq      <= 8'h00;
      hdr_len      <= 8'h00;
      fill_count   <= '0;
      running_crc  <= CRC_INIT;
      crc_low_byte <= 8'h00;
      prev_time    <= 32'h0000_0000;
    end else begin
      phase        <= phase_next;
      hdr_dest     <= hdr_dest_next;
      hdr_source   <= hdr_source_next;
      hdr_kind     <= hdr_kind_next;
      hdr_seq      <= hdr_seq_next;
      hdr_len      <= hdr_len_next;
      fill_count   <= fill_count_next;
      running_crc  <= running_crc_next;
      crc_low_byte <= crc_low_byte_next;
      prev_time    <= prev_time_next;
    end
  end

  // Payload store and result sequencing.
  fpc_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .wr_en       (wr_en),
    .wr_addr     (fill_count[PAY_AW-1:0]),
    .wr_data     (rx_byte),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .run_busy    (run_busy),
    .status      (status),
    .dest_addr   (dest_addr),
    .source_addr (source_addr),
    .msg_kind    (msg_kind),
    .seq_num     (seq_num),
    .payload_len (payload_len),
    .has_data    (has_data),
    .data_byte   (data_byte),
    .data_index  (data_index),
    .last        (last)
  );

`ifndef SYNTHESIS
  // A single result is never issued over a stalled word.
  a_single_has_room: assert property (@(posedge clk) disable iff (rst)
    req.single |-> !(out_valid && out_stall))
    else $error("single result issued while the output register was stalled");

  // A new run never starts inside another.
  a_run_not_nested: assert property (@(posedge clk) disable iff (rst)
    req.run |-> !run_busy)
    else $error("payload run started while one was active");

  // While collecting payload the fill count stays below the length.
  a_fill_below_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (8'(fill_count) < hdr_len))
    else $error("payload fill count reached the length inside the data phase");
`endif

endmodule

// ===== bench/tb_frame_parser_crc16_core.sv =====
`timescale 1ns / 100ps

import fpc_pkg::*;

// Order in which the parser walks through a frame.
typedef enum logic [3:0] {
  HUNT_FIRST,
  HUNT_SECOND,
  GET_DEST,
  GET_SOURCE,
  GET_KIND,
  GET_SEQ,
  GET_LEN,
  GET_DATA,
  GET_CRC_LO,
  GET_CRC_HI
} parse_step_e;

// Kinds of byte sequences the stimulus builds.
typedef enum {
  SHAPE_GOOD,
  SHAPE_BAD_CRC,
  SHAPE_ZERO_KIND,
  SHAPE_BCAST_SRC,
  SHAPE_LONG,
  SHAPE_GAP_DROP,
  SHAPE_NOISE
} frame_shape_e;

// One output word of the parser.
typedef struct packed {
  logic [ST_W-1:0]  status;
  logic [7:0]       dest;
  logic [7:0]       source;
  logic [7:0]       kind;
  logic [7:0]       seq;
  logic [7:0]       len;
  logic             has;
  logic [7:0]       data;
  logic [IDX_W-1:0] idx;
  logic             last;
} frame_word_t;

typedef logic [7:0] byte_q_t[$];

// Reflected CRC-16/MODBUS update over one byte.
function automatic logic [15:0] crc_modbus_step(input logic [15:0] acc, input logic [7:0] b);
  logic [15:0] c;
  int k;
  c = acc ^ {8'h00, b};
  for (k = 0; k < 8; k++) begin
    c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  end
  return c;
endfunction

// CRC of a byte queue from a given position to its end.
function automatic logic [15:0] crc_over(input byte_q_t q, input int from);
  logic [15:0] c;
  int k;
  c = CRC_INIT;
  for (k = from; k < q.size(); k++) begin
    c = crc_modbus_step(c, q[k]);
  end
  return c;
endfunction

// Tracks the parser state for every accepted byte and holds the words it owes.
class frame_scoreboard;
  logic [7:0]  sync_a;
  logic [7:0]  sync_b;
  logic [15:0] gap_limit;

  parse_step_e step;
  logic [7:0]  dest;
  logic [7:0]  source;
  logic [7:0]  kind;
  logic [7:0]  seq;
  logic [7:0]  len;
  logic [5:0]  fill;
  logic [15:0] crc;
  logic [7:0]  crc_lo;
  logic [31:0] last_time;
  logic [7:0]  payload_buf [MAX_PAYLOAD];

  frame_word_t words_due[$];
  int errors;

  function new();
    sync_a    = 8'hAA;
    sync_b    = 8'h55;
    gap_limit = 16'd50;
    last_time = '0;
    errors    = 0;
    drop_frame();
  endfunction

  function void drop_frame();
    step   = HUNT_FIRST;
    dest   = '0;
    source = '0;
    kind   = '0;
    seq    = '0;
    len    = '0;
    fill   = '0;
    crc    = CRC_INIT;
    crc_lo = '0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SYNC_FIRST:  sync_a = val[7:0];
      CFG_SYNC_SECOND: sync_b = val[7:0];
      CFG_GAP_TIMEOUT: gap_limit = val;
      default: ;
    endcase
  endfunction

  function void add_word(logic [ST_W-1:0] st, logic has, logic [7:0] d,
                         logic [IDX_W-1:0] ix, logic lst);
    frame_word_t w;
    w.status = st;
    w.dest   = dest;
    w.source = source;
    w.kind   = kind;
    w.seq    = seq;
    w.len    = len;
    w.has    = has;
    w.data   = d;
    w.idx    = ix;
    w.last   = lst;
    words_due.push_back(w);
  endfunction

  // Advance the parser by one received byte and queue the words it releases.
  function void parse_byte(logic [7:0] b, logic [31:0] t);
    logic [31:0]     gap;
    logic [ST_W-1:0] st;
    int              i;
    if (step != HUNT_FIRST) begin
      gap = t - last_time;
      if (gap > {16'h0000, gap_limit}) drop_frame();
    end
    last_time = t;
    case (step)
      HUNT_FIRST: begin
        if (b == sync_a) step = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        // The second sync wins when both sync values are equal.
        if (b == sync_b) begin
          step = GET_DEST;
          crc  = CRC_INIT;
        end else if (b != sync_a) begin
          step = HUNT_FIRST;
        end
      end
      GET_DEST: begin
        dest = b;
        crc  = crc_modbus_step(crc, b);
        step = GET_SOURCE;
      end
      GET_SOURCE: begin
        source = b;
        crc    = crc_modbus_step(crc, b);
        step   = GET_KIND;
      end
      GET_KIND: begin
        kind = b;
        crc  = crc_modbus_step(crc, b);
        step = GET_SEQ;
      end
      GET_SEQ: begin
        seq  = b;
        crc  = crc_modbus_step(crc, b);
        step = GET_LEN;
      end
      GET_LEN: begin
        len  = b;
        crc  = crc_modbus_step(crc, b);
        fill = '0;
        if (b > MAX_LEN) begin
          add_word(ST_LEN, 1'b0, 8'h00, '0, 1'b1);
          drop_frame();
        end else begin
          step = (b == 8'h00) ? GET_CRC_LO : GET_DATA;
        end
      end
      GET_DATA: begin
        if (fill < MAX_PAYLOAD) payload_buf[fill] = b;
        crc  = crc_modbus_step(crc, b);
        fill = fill + 6'd1;
        if ({2'b00, fill} >= len) step = GET_CRC_LO;
      end
      GET_CRC_LO: begin
        crc_lo = b;
        step   = GET_CRC_HI;
      end
      GET_CRC_HI: begin
        if ({b, crc_lo} != crc) st = ST_CRC;
        else if (kind == 8'h00) st = ST_KIND;
        else if (source == BCAST_ADDR) st = ST_BCAST;
        else st = ST_GOOD;
        if (st != ST_GOOD) begin
          add_word(st, 1'b0, 8'h00, '0, 1'b1);
          drop_frame();
        end else begin
          if (len == 8'h00) begin
            add_word(ST_GOOD, 1'b0, 8'h00, '0, 1'b1);
          end else begin
            for (i = 0; i < len && i < MAX_PAYLOAD; i++) begin
              add_word(ST_GOOD, 1'b1, payload_buf[i], i[IDX_W-1:0], (i + 1 == len));
            end
          end
          step = HUNT_FIRST;
        end
      end
      default: drop_frame();
    endcase
  endfunction

  function void compare(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Compare one output word with the oldest one owed.
  function void check_word(frame_word_t got);
    frame_word_t want;
    if (words_due.size() == 0) begin
      errors++;
      $display("%0t: word with nothing expected, expected none, actual status %0h data %0h",
               $time, got.status, got.data);
    end else begin
      want = words_due.pop_front();
      compare("status", want.status, got.status);
      compare("dest_addr", want.dest, got.dest);
      compare("source_addr", want.source, got.source);
      compare("msg_kind", want.kind, got.kind);
      compare("seq_num", want.seq, got.seq);
      compare("payload_len", want.len, got.len);
      compare("has_data", want.has, got.has);
      compare("data_byte", want.data, got.data);
      compare("data_index", want.idx, got.idx);
      compare("last", want.last, got.last);
    end
  endfunction

  function int pending();
    return words_due.size();
  endfunction
endclass

module tb_frame_parser_crc16_core;

  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_WORDS  = 20;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            rx_byte = '0;
  logic [31:0]           now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ST_W-1:0]       status;
  logic [7:0]            dest_addr;
  logic [7:0]            source_addr;
  logic [7:0]            msg_kind;
  logic [7:0]            seq_num;
  logic [7:0]            payload_len;
  logic                  has_data;
  logic [7:0]            data_byte;
  logic [IDX_W-1:0]      data_index;
  logic                  last;

  frame_scoreboard frames = new();
  frame_word_t     seen_word;

  int          send_idle_pct = 25;
  int          recv_idle_pct = 81;
  int          words_sent = 0;
  int          stuck_cycles = 0;
  int          hold_left = 0;
  logic        hold_request = 1'b0;
  logic [31:0] t_now = '0;

  frame_parser_crc16_core DUT (.*);

  always #4 clk = ~clk;

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every word the receiver takes.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_word = '{status, dest_addr, source_addr, msg_kind, seq_num, payload_len,
                    has_data, data_byte, data_index, last};
      frames.check_word(seen_word);
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    frames.set_reg(idx, val);
  endtask

  // Offer one byte, with random idle cycles ahead of it, until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    now_ms   = t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames.parse_byte(b, t);
    words_sent++;
  endtask

  // Send a byte sequence; at position jump_at the time leaps past the timeout.
  task automatic send_seq(input byte_q_t q, input int jump_at);
    logic [31:0] dt;
    int          i;
    for (i = 0; i < q.size(); i++) begin
      if (i == jump_at) dt = {16'h0000, frames.gap_limit} + 32'd1 + $urandom_range(0, 100000);
      else if ($urandom_range(3) == 0) dt = {16'h0000, frames.gap_limit};
      else dt = $urandom_range(0, frames.gap_limit);
      t_now = t_now + dt;
      send_byte(q[i], t_now);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Build a frame of the given shape with random content and send it.
  task automatic send_frame(input frame_shape_e shape, input int len_hint);
    byte_q_t     q;
    logic [7:0]  len_b;
    logic [15:0] crc;
    int          hdr_at;
    int          jump_at;
    jump_at = -1;
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
    end else begin
      q.push_back(frames.sync_a);
      if ($urandom_range(3) == 0) q.push_back(frames.sync_a);
      q.push_back(frames.sync_b);
      hdr_at = q.size();
      q.push_back(8'($urandom));
      q.push_back((shape == SHAPE_BCAST_SRC) ? BCAST_ADDR : 8'($urandom_range(0, 254)));
      q.push_back((shape == SHAPE_ZERO_KIND) ? 8'h00 : 8'($urandom_range(1, 255)));
      q.push_back(8'($urandom));
      if (shape == SHAPE_LONG) begin
        len_b = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
      end else if (len_hint >= 0) begin
        len_b = 8'(len_hint);
      end else begin
        case ($urandom_range(9))
          0, 1:    len_b = 8'h00;
          8:       len_b = MAX_LEN;
          9:       len_b = 8'($urandom_range(7, MAX_PAYLOAD - 1));
          default: len_b = 8'($urandom_range(1, 6));
        endcase
      end
      q.push_back(len_b);
      // An oversized length ends the frame right after the length byte.
      if (shape != SHAPE_LONG) begin
        repeat (len_b) q.push_back(8'($urandom));
        crc = crc_over(q, hdr_at);
        if (shape == SHAPE_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(15));
        q.push_back(crc[7:0]);
        q.push_back(crc[15:8]);
      end
      if (shape == SHAPE_GAP_DROP) jump_at = $urandom_range(1, q.size() - 1);
    end
    send_seq(q, jump_at);
  endtask

  task automatic wait_drained();
    while (frames.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    byte_q_t      q;
    logic [15:0]  crc;
    logic [7:0]   first_sync;
    logic [7:0]   second_sync;
    logic [15:0]  gap_ms;
    frame_shape_e shape;
    int           ph;
    int           phase_start;
    int           r;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frames at reset settings, with the time wrapping past zero.
    t_now = 32'hFFFF_FFC0;
    q = '{8'hAA, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h00};
    crc = crc_over(q, 3);
    q.push_back(crc[7:0]);
    q.push_back(crc[15:8]);
    send_seq(q, -1);
    q = '{8'hAA, 8'h55, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
    send_seq(q, -1);
    q = '{8'hAA, 8'h55, 8'h12, 8'h34, 8'h56, 8'h78, 8'hAA};
    send_seq(q, 6);

    // Hold the receiver while two full frames are offered, then let it all drain.
    hold_request = 1'b1;
    send_frame(SHAPE_GOOD, MAX_PAYLOAD);
    send_frame(SHAPE_GOOD, MAX_PAYLOAD);
    wait_drained();

    // Random frames under several register settings and idle patterns.
    for (ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 25;
        recv_idle_pct = 81;
      end else if (ph < 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: begin first_sync = 8'hAA; second_sync = 8'h55; gap_ms = 16'd50; end
        1: begin first_sync = 8'h00; second_sync = 8'hFF; gap_ms = 16'd0; end
        2: begin first_sync = 8'h7E; second_sync = 8'h7E; gap_ms = 16'hFFFF; end
        3: begin first_sync = 8'hFF; second_sync = 8'h00; gap_ms = 16'd1; end
        4: begin first_sync = 8'($urandom); second_sync = 8'($urandom); gap_ms = 16'($urandom); end
        default: begin first_sync = 8'($urandom); second_sync = 8'($urandom); gap_ms = 16'd1000; end
      endcase
      wait_drained();
      write_reg(CFG_SYNC_FIRST, {8'h00, first_sync});
      write_reg(CFG_SYNC_SECOND, {8'h00, second_sync});
      write_reg(CFG_GAP_TIMEOUT, gap_ms);
      t_now = (ph == 1) ? 32'hFFFF_FFF0 : $urandom;
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        r = $urandom_range(99);
        if (r < 55) shape = SHAPE_GOOD;
        else if (r < 63) shape = SHAPE_BAD_CRC;
        else if (r < 70) shape = SHAPE_ZERO_KIND;
        else if (r < 77) shape = SHAPE_BCAST_SRC;
        else if (r < 85) shape = SHAPE_LONG;
        else if (r < 93) shape = SHAPE_GAP_DROP;
        else shape = SHAPE_NOISE;
        send_frame(shape, -1);
      end
    end

    wait_drained();
    if (frames.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
